// ===== src/tfuc_pkg.sv =====
// Shared types and constants for the tire friction usage cost block.
package tfuc_pkg;

    localparam int WHEEL_COUNT_DEF = 4;
    localparam int USAGE_FRAC_DEF  = 16;
    localparam int FORCE_W         = 16;
    localparam int CAP_W           = 16;
    localparam int WEIGHT_W        = 16;
    localparam int USAGE_W         = 24;
    localparam int MAG_W           = 24;
    localparam int COST_W          = 32;
    localparam int TERM_W          = 52;
    localparam int SUM_W           = 54;
    localparam int CLAMP_W         = 41;
    localparam int LANE_LAT        = 53;
    localparam int MERGE_LAT       = 6;
    localparam int FIFO_DEPTH      = 64;
    localparam int ADDR_W          = 5;

    localparam logic [2:0] REG_WHEEL0 = 3'd0;
    localparam logic [2:0] REG_WHEEL1 = 3'd1;
    localparam logic [2:0] REG_WHEEL2 = 3'd2;
    localparam logic [2:0] REG_WHEEL3 = 3'd3;
    localparam logic [2:0] REG_USAGE_WEIGHT  = 3'd4;
    localparam logic [2:0] REG_MARGIN_WEIGHT = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    typedef struct packed {
        logic [TERM_W-1:0]  term;
        logic [USAGE_W-1:0] usage;
    } lane_res_t;

endpackage

// ===== src/tfuc_lane.sv =====
// One wheel lane: force magnitude, utilization division and per-wheel cost term.
module tfuc_lane #(
    parameter int USAGE_FRAC_BITS = tfuc_pkg::USAGE_FRAC_DEF
) (
    input  logic                                aclk,
    input  logic signed [tfuc_pkg::FORCE_W-1:0] fx,
    input  logic signed [tfuc_pkg::FORCE_W-1:0] fy,
    input  logic [tfuc_pkg::CAP_W-1:0]          capacity,
    output tfuc_pkg::lane_res_t                 res
);
    import tfuc_pkg::*;

    localparam int REM_W = 27;
    localparam int NW    = MAG_W + USAGE_FRAC_BITS;
    localparam logic [USAGE_W:0] ONE = (USAGE_W+1)'(1) << USAGE_FRAC_BITS;

    logic [FORCE_W-1:0] ax_reg, ay_reg;
    logic [31:0]        sq_reg;

    always_ff @(posedge aclk) begin
        ax_reg <= fx[FORCE_W-1] ? FORCE_W'(-fx) : FORCE_W'(fx);
        ay_reg <= fy[FORCE_W-1] ? FORCE_W'(-fy) : FORCE_W'(fy);
        sq_reg <= 32'(32'(ax_reg) * 32'(ax_reg)) + 32'(32'(ay_reg) * 32'(ay_reg));
    end

    logic [REM_W-1:0] srem_reg [1:MAG_W];
    logic [MAG_W-1:0] root_reg [1:MAG_W];
    logic [47:0]      rad_reg  [1:MAG_W];

    for (genvar k = 0; k < MAG_W; k++) begin : g_sqrt
        logic [REM_W-1:0] srem_in;
        logic [MAG_W-1:0] root_in;
        logic [47:0]      rad_in;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        if (k == 0) begin : g_first
            assign srem_in = '0;
            assign root_in = '0;
            assign rad_in  = {sq_reg, 16'b0};
        end else begin : g_next
            assign srem_in = srem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
        end
        assign rem2  = {srem_in[REM_W-3:0], rad_in[47:46]};
        assign trial = {1'b0, root_in, 2'b01};
        always_ff @(posedge aclk) begin
            rad_reg[k+1] <= {rad_in[45:0], 2'b00};
            if (rem2 >= trial) begin
                srem_reg[k+1] <= rem2 - trial;
                root_reg[k+1] <= {root_in[MAG_W-2:0], 1'b1};
            end else begin
                srem_reg[k+1] <= rem2;
                root_reg[k+1] <= {root_in[MAG_W-2:0], 1'b0};
            end
        end
    end

    logic [NW-1:0]      num;
    logic [USAGE_W-1:0] den;
    logic [USAGE_W:0]   num_hi;

    assign num    = {root_reg[MAG_W], {USAGE_FRAC_BITS{1'b0}}};
    assign den    = {capacity, 8'b0};
    assign num_hi = (USAGE_W+1)'(num[NW-1:USAGE_W]);

    logic [USAGE_W:0]   drem_reg [USAGE_W+1];
    logic [USAGE_W-1:0] dlo_reg  [USAGE_W+1];
    logic [USAGE_W-1:0] q_reg    [USAGE_W+1];
    logic               sat_reg  [USAGE_W+1];

    always_ff @(posedge aclk) begin
        drem_reg[0] <= num_hi;
        dlo_reg[0]  <= num[USAGE_W-1:0];
        q_reg[0]    <= '0;
        sat_reg[0]  <= num_hi >= {1'b0, den};
    end

    for (genvar k = 0; k < USAGE_W; k++) begin : g_div
        logic [USAGE_W:0] rem2;
        assign rem2 = {drem_reg[k][USAGE_W-1:0], dlo_reg[k][USAGE_W-1]};
        always_ff @(posedge aclk) begin
            dlo_reg[k+1] <= {dlo_reg[k][USAGE_W-2:0], 1'b0};
            sat_reg[k+1] <= sat_reg[k];
            if (rem2 >= {1'b0, den}) begin
                drem_reg[k+1] <= rem2 - {1'b0, den};
                q_reg[k+1]    <= {q_reg[k][USAGE_W-2:0], 1'b1};
            end else begin
                drem_reg[k+1] <= rem2;
                q_reg[k+1]    <= {q_reg[k][USAGE_W-2:0], 1'b0};
            end
        end
    end

    logic [USAGE_W-1:0]   u;
    logic [USAGE_W-1:0]   e;
    logic [2*USAGE_W-1:0] usq_reg, esq_reg;
    logic [USAGE_W-1:0]   u_reg;

    assign u = sat_reg[USAGE_W] ? {USAGE_W{1'b1}} : q_reg[USAGE_W];
    assign e = ({1'b0, u} > ONE) ? USAGE_W'({1'b0, u} - ONE) : '0;

    always_ff @(posedge aclk) begin
        usq_reg <= (2*USAGE_W)'(u) * (2*USAGE_W)'(u);
        esq_reg <= (2*USAGE_W)'(e) * (2*USAGE_W)'(e);
        u_reg   <= u;
        if (capacity == '0) begin
            res <= '0;
        end else begin
            res.term  <= TERM_W'(usq_reg) + TERM_W'(esq_reg) * TERM_W'(10);
            res.usage <= u_reg;
        end
    end

endmodule

// ===== src/tfuc_merge.sv =====
// Merging stage: sums lane terms, finds the peak and applies the weights.
module tfuc_merge #(
    parameter int WHEEL_COUNT     = tfuc_pkg::WHEEL_COUNT_DEF,
    parameter int USAGE_FRAC_BITS = tfuc_pkg::USAGE_FRAC_DEF
) (
    input  logic                              aclk,
    input  tfuc_pkg::lane_res_t               lane_res [WHEEL_COUNT],
    input  logic [tfuc_pkg::WEIGHT_W-1:0]     usage_weight,
    input  logic [tfuc_pkg::WEIGHT_W-1:0]     margin_weight,
    output logic [tfuc_pkg::COST_W-1:0]       usage_cost,
    output logic [tfuc_pkg::COST_W-1:0]       margin_cost,
    output logic [tfuc_pkg::USAGE_W-1:0]      peak_usage
);
    import tfuc_pkg::*;

    localparam int DOWN = 2 * USAGE_FRAC_BITS - 16;
    localparam logic [USAGE_W-1:0] THR = USAGE_W'((64'(4) << USAGE_FRAC_BITS) / 5);
    localparam logic [SUM_W-1:0]   CLAMP_S = SUM_W'(1) << (CLAMP_W - 1);
    localparam int MW = CLAMP_W + WEIGHT_W;
    localparam logic [MW-9:0] COST_LIM = (MW-8)'({COST_W{1'b1}});

    logic [SUM_W-1:0]   sum;
    logic [USAGE_W-1:0] peak;

    always_comb begin
        sum  = '0;
        peak = '0;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            sum = sum + SUM_W'(lane_res[i].term);
            if (lane_res[i].usage > peak) begin
                peak = lane_res[i].usage;
            end
        end
    end

    logic [SUM_W-1:0]     sum_reg;
    logic [USAGE_W-1:0]   peak0_reg, peak1_reg, peak2_reg, peak3_reg, peak4_reg;
    logic [CLAMP_W-1:0]   uq_reg, mq_reg;
    logic [USAGE_W-1:0]   d_reg;
    logic [MW-1:0]        uw_reg, mw_reg;
    logic [2*USAGE_W-1:0] dsq_reg;
    logic [COST_W-1:0]    usage3_reg, usage4_reg;
    logic [SUM_W-1:0]     sum_sh;
    logic [SUM_W-1:0]     dsq_sh;
    logic [MW-9:0]        uw_sh, mw_sh;

    assign sum_sh = sum_reg >> DOWN;
    assign dsq_sh = SUM_W'(dsq_reg >> DOWN);
    assign uw_sh  = uw_reg[MW-1:8];
    assign mw_sh  = mw_reg[MW-1:8];

    always_ff @(posedge aclk) begin
        sum_reg    <= sum;
        peak0_reg  <= peak;
        uq_reg     <= (sum_sh > CLAMP_S) ? CLAMP_W'(CLAMP_S) : CLAMP_W'(sum_sh);
        d_reg      <= (peak0_reg > THR) ? peak0_reg - THR : '0;
        peak1_reg  <= peak0_reg;
        uw_reg     <= MW'(uq_reg) * MW'(usage_weight);
        dsq_reg    <= (2*USAGE_W)'(d_reg) * (2*USAGE_W)'(d_reg);
        peak2_reg  <= peak1_reg;
        usage3_reg <= (uw_sh > COST_LIM) ? {COST_W{1'b1}} : COST_W'(uw_sh);
        mq_reg     <= (dsq_sh > CLAMP_S) ? CLAMP_W'(CLAMP_S) : CLAMP_W'(dsq_sh);
        peak3_reg  <= peak2_reg;
        mw_reg     <= MW'(mq_reg) * MW'(margin_weight);
        usage4_reg <= usage3_reg;
        peak4_reg  <= peak3_reg;
        margin_cost <= (mw_sh > COST_LIM) ? {COST_W{1'b1}} : COST_W'(mw_sh);
        usage_cost  <= usage4_reg;
        peak_usage  <= peak4_reg;
    end

endmodule

// ===== src/tire_friction_usage_cost_top.sv =====
// Top level of the tire friction usage cost block: register port, lanes and output queue.
//
// Each transaction carries the horizontal force of four wheels and yields one result
// transaction with the weighted utilization cost, the weighted margin cost and the peak
// utilization. One wheel lane per wheel computes the force magnitude in a 24-step
// square root pipeline and the utilization in a 24-step divider pipeline; a merging
// stage sums the terms and applies the weights. A new transaction is taken every
// cycle while the queue has room; a result passes through 59 pipeline stages, the
// queue write and the output register. Results collect in a 64-entry queue, so input
// is held off only when 64 transactions are in flight or waiting downstream. It is up
// to the user to make configuration writes only while no transaction is in flight.
module tire_friction_usage_cost_top #(
    parameter int WHEEL_COUNT     = tfuc_pkg::WHEEL_COUNT_DEF,
    parameter int USAGE_FRAC_BITS = tfuc_pkg::USAGE_FRAC_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfuc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // wheel0_fx, wheel0_fy, wheel1_fx, wheel1_fy, wheel2_fx, wheel2_fy, wheel3_fx, wheel3_fy
    input  logic [127:0]                s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // usage_cost, margin_cost, peak_usage
    output logic [87:0]                 m_tdata
);
    import tfuc_pkg::*;

    localparam int LAT   = LANE_LAT + MERGE_LAT;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [CAP_W-1:0]    cap_reg [4];
    logic [WEIGHT_W-1:0] usage_w_reg, margin_w_reg;
    logic [2:0]          reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                cap_reg[i] <= '0;
            end
            usage_w_reg  <= WEIGHT_RESET;
            margin_w_reg <= WEIGHT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WHEEL0:        cap_reg[0]   <= pwdata[15:0];
                REG_WHEEL1:        cap_reg[1]   <= pwdata[15:0];
                REG_WHEEL2:        cap_reg[2]   <= pwdata[15:0];
                REG_WHEEL3:        cap_reg[3]   <= pwdata[15:0];
                REG_USAGE_WEIGHT:  usage_w_reg  <= pwdata[15:0];
                REG_MARGIN_WEIGHT: margin_w_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WHEEL0:        prdata = 32'(cap_reg[0]);
            REG_WHEEL1:        prdata = 32'(cap_reg[1]);
            REG_WHEEL2:        prdata = 32'(cap_reg[2]);
            REG_WHEEL3:        prdata = 32'(cap_reg[3]);
            REG_USAGE_WEIGHT:  prdata = 32'(usage_w_reg);
            REG_MARGIN_WEIGHT: prdata = 32'(margin_w_reg);
            default:           prdata = '0;
        endcase
    end

    lane_res_t lane_res [WHEEL_COUNT];

    for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_lane
        tfuc_lane #(
            .USAGE_FRAC_BITS(USAGE_FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .fx       (s_tdata[32*i +: 16]),
            .fy       (s_tdata[32*i+16 +: 16]),
            .capacity (cap_reg[i]),
            .res      (lane_res[i])
        );
    end

    logic [COST_W-1:0]  usage_cost, margin_cost;
    logic [USAGE_W-1:0] peak_usage;

    tfuc_merge #(
        .WHEEL_COUNT    (WHEEL_COUNT),
        .USAGE_FRAC_BITS(USAGE_FRAC_BITS)
    ) u_merge (
        .aclk          (aclk),
        .lane_res      (lane_res),
        .usage_weight  (usage_w_reg),
        .margin_weight (margin_w_reg),
        .usage_cost    (usage_cost),
        .margin_cost   (margin_cost),
        .peak_usage    (peak_usage)
    );

    logic             in_acc, out_acc, load;
    logic [LAT-1:0]   vld_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] mem_cnt_reg, mem_cnt_next;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic             out_vld_reg, out_vld_next;
    logic [87:0]      mem [FIFO_DEPTH];
    logic [87:0]      out_data_reg;
    logic             wr;

    assign s_tready = occ_reg < CNT_W'(FIFO_DEPTH);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = out_vld_reg && m_tready;
    assign wr       = vld_reg[LAT-1];
    assign load     = (mem_cnt_reg != '0) && (!out_vld_reg || m_tready);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        occ_next     = occ_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
        mem_cnt_next = mem_cnt_reg + CNT_W'(wr) - CNT_W'(load);
        out_vld_next = load ? 1'b1 : (out_acc ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            occ_reg     <= '0;
            mem_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            vld_reg     <= {vld_reg[LAT-2:0], in_acc};
            occ_reg     <= occ_next;
            mem_cnt_reg <= mem_cnt_next;
            out_vld_reg <= out_vld_next;
            if (wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (load) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wr_ptr_reg] <= {peak_usage, margin_cost, usage_cost};
        end
        if (load) begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(FIFO_DEPTH))
        else $error("In-flight count exceeds the queue depth.");
    a_mem_within_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_cnt_reg <= occ_reg)
        else $error("Queue holds more results than transactions in flight.");
    a_out_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> occ_reg != '0)
        else $error("Result presented with no transaction outstanding.");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> out_vld_reg)
        else $error("Queue read did not present a result.");
`endif

endmodule

// ===== tb/tb_tire_friction_usage_cost_top.sv =====
// Self-checking testbench for the tire friction usage cost block.
`timescale 1ns / 100ps

module tb_tire_friction_usage_cost_top;
    import tfuc_pkg::*;

    typedef struct {
        logic [127:0] forces;
        bit           typed;
        logic [31:0]  usage_cost;
        logic [31:0]  margin_cost;
        logic [23:0]  peak_usage;
    } cost_row_t;

    typedef struct {
        logic [31:0] usage_cost;
        logic [31:0] margin_cost;
        logic [23:0] peak_usage;
    } cost_res_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 70;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    logic [15:0]  cap_q [4];
    logic [15:0]  usage_weight_q;
    logic [15:0]  margin_weight_q;

    cost_row_t    row_q [$];
    cost_res_t    cost_q [$];
    int           err_cnt = 0;
    int           item_cnt = 0;
    int           res_cnt = 0;
    int           phase_cnt = 0;
    int           stall_cnt = 0;
    bit           no_idle = 1'b0;
    bit           running = 1'b0;

    always #5 aclk = ~aclk;

    tire_friction_usage_cost_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] apply_weight(longint unsigned q16, logic [15:0] w);
        longint unsigned r;
        if (q16 > (64'd1 << 40)) q16 = 64'd1 << 40;
        r = (q16 * w) >> 8;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic cost_res_t friction_cost(logic [127:0] forces);
        cost_res_t       res;
        longint unsigned sum, peak, ax, ay, mag, u, e, d, thr;
        logic signed [15:0] f;
        sum = 0;
        peak = 0;
        thr = (64'd4 << 16) / 5;
        for (int k = 0; k < 4; k++) begin
            if (cap_q[k] != 0) begin
                f = forces[32*k +: 16];
                ax = (f < 0) ? -longint'(f) : longint'(f);
                f = forces[32*k+16 +: 16];
                ay = (f < 0) ? -longint'(f) : longint'(f);
                mag = isqrt((ax * ax + ay * ay) << 16);
                u = (mag << 16) / (longint'(cap_q[k]) << 8);
                if (u > 64'hFF_FFFF) u = 64'hFF_FFFF;
                sum += u * u;
                if (u > (64'd1 << 16)) begin
                    e = u - (64'd1 << 16);
                    sum += 10 * e * e;
                end
                if (u > peak) peak = u;
            end
        end
        d = (peak > thr) ? peak - thr : 0;
        res.usage_cost  = apply_weight(sum >> 16, usage_weight_q);
        res.margin_cost = apply_weight((d * d) >> 16, margin_weight_q);
        res.peak_usage  = peak[23:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        err_cnt++;
    endtask

    // Predict on every accepted input transaction and check every accepted result.
    always @(posedge aclk) begin
        cost_row_t row;
        cost_res_t exp;
        if (aresetn && s_tvalid && s_tready) begin
            row = row_q.pop_front();
            if (row.typed) begin
                exp.usage_cost = row.usage_cost;
                exp.margin_cost = row.margin_cost;
                exp.peak_usage = row.peak_usage;
            end else begin
                exp = friction_cost(s_tdata);
            end
            cost_q.push_back(exp);
        end
        if (aresetn && m_tvalid && m_tready) begin
            res_cnt++;
            if (cost_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                exp = cost_q.pop_front();
                if (m_tdata[31:0] !== exp.usage_cost)
                    report_mismatch("usage_cost", 64'(m_tdata[31:0]), 64'(exp.usage_cost));
                if (m_tdata[63:32] !== exp.margin_cost)
                    report_mismatch("margin_cost", 64'(m_tdata[63:32]),
                                    64'(exp.margin_cost));
                if (m_tdata[87:64] !== exp.peak_usage)
                    report_mismatch("peak_usage", 64'(m_tdata[87:64]), 64'(exp.peak_usage));
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end

    always @(posedge aclk) begin
        if (!running || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", cost_q.size());
                $display("tb_tire_friction_usage_cost_top failed");
                $finish;
            end
        end
    end

    task automatic write_reg(int idx, logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < 4) cap_q[idx] = value;
        else if (idx == REG_USAGE_WEIGHT) usage_weight_q = value;
        else if (idx == REG_MARGIN_WEIGHT) margin_weight_q = value;
    endtask

    task automatic drain();
        wait (cost_q.size() == 0 && row_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                             logic [15:0] c3, logic [15:0] uw, logic [15:0] mw);
        drain();
        write_reg(REG_WHEEL0, c0);
        write_reg(REG_WHEEL1, c1);
        write_reg(REG_WHEEL2, c2);
        write_reg(REG_WHEEL3, c3);
        write_reg(REG_USAGE_WEIGHT, uw);
        write_reg(REG_MARGIN_WEIGHT, mw);
        phase_cnt++;
    endtask

    task automatic send_forces(cost_row_t row);
        if (!no_idle && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        row_q.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata <= row.forces;
        do @(posedge aclk); while (!s_tready);
        item_cnt++;
    endtask

    function automatic logic [15:0] rand_force(logic [15:0] cap);
        int lim;
        if (cap == 0 || $urandom_range(0, 99) < 35) return 16'($urandom);
        lim = 2 * int'(cap);
        if (lim > 32767) lim = 32767;
        return 16'($urandom_range(0, 2 * lim) - lim);
    endfunction

    task automatic random_phase(int n);
        cost_row_t row;
        row.typed = 1'b0;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 4; k++) begin
                row.forces[32*k +: 16] = rand_force(cap_q[k]);
                row.forces[32*k+16 +: 16] = rand_force(cap_q[k]);
            end
            send_forces(row);
        end
    endtask

    cost_row_t dir_rows [] = '{
        '{{8{16'h0000}}, 1'b1, 32'h0, 32'h0, 24'h0},
        '{{8{16'h8000}}, 1'b1, 32'h0, 32'h0, 24'h0},
        '{{8{16'h7FFF}}, 1'b1, 32'h0, 32'h0, 24'h0},
        '{{8{16'h0000}}, 1'b1, 32'h0, 32'h0, 24'h0},
        '{{8{16'h7FFF}}, 1'b0, 32'h0, 32'h0, 24'h0},
        '{{8{16'h8000}}, 1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'd1000, 16'h0000, 16'd1, 16'h0000, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'd1001, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'd800, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h0000, 16'h0000, 16'h0000, 16'd801, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0},
        '{{16'h0000, 16'h0000, 16'd600, 16'hFE0C, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b0, 32'h0, 32'h0, 24'h0}
    };

    initial begin
        cap_q = '{default: 16'h0};
        usage_weight_q = WEIGHT_RESET;
        margin_weight_q = WEIGHT_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        running = 1'b1;
        @(posedge aclk);

        // With reset registers every wheel is skipped.
        for (int i = 0; i < 4; i++) send_forces(dir_rows[i]);
        s_tvalid <= 1'b0;
        configure(16'd1, 16'd65535, 16'd1000, 16'd0, 16'd65535, 16'd256);
        // Writes beyond the register list must be ignored.
        write_reg(6, 16'hFFFF);
        write_reg(7, 16'h1234);
        for (int i = 4; i < dir_rows.size(); i++) send_forces(dir_rows[i]);
        s_tvalid <= 1'b0;
        configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd65535, 16'd65535);
        for (int i = 4; i < 7; i++) send_forces(dir_rows[i]);
        s_tvalid <= 1'b0;

        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        random_phase(120);
        s_tvalid <= 1'b0;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        no_idle = 1'b1;
        random_phase(120);
        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        configure(16'($urandom_range(10, 2000)), 16'($urandom_range(10, 2000)),
                  16'($urandom_range(10, 2000)), 16'($urandom_range(10, 2000)),
                  WEIGHT_RESET, WEIGHT_RESET);
        random_phase(130);
        s_tvalid <= 1'b0;
        configure(16'd0, 16'($urandom_range(1, 500)), 16'd0, 16'($urandom),
                  16'($urandom_range(0, 1024)), 16'hFFFF);
        random_phase(120);
        s_tvalid <= 1'b0;
        configure(16'd1, 16'($urandom_range(1, 50)), 16'hFFFF, 16'($urandom_range(1, 30000)),
                  16'hFFFF, 16'($urandom_range(1, 1024)));
        random_phase(120);
        s_tvalid <= 1'b0;
        configure(16'($urandom_range(100, 8000)), 16'($urandom_range(100, 8000)),
                  16'($urandom_range(100, 8000)), 16'($urandom_range(100, 8000)),
                  16'($urandom), 16'($urandom));
        random_phase(120);
        s_tvalid <= 1'b0;
        drain();

        $display("Sent %0d force sets over %0d register settings, checked %0d results.",
                 item_cnt, phase_cnt + 1, res_cnt);
        if (err_cnt == 0) begin
            $display("tb_tire_friction_usage_cost_top passed");
        end else begin
            $display("%0d mismatches found.", err_cnt);
            $display("tb_tire_friction_usage_cost_top failed");
        end
        $finish;
    end
endmodule
